@@ rtl/rbcs_pkg.sv @@
package rbcs_pkg;

  // Character set codes as written to the charset_select register
  typedef enum logic [1:0] {
    CS_PRINT = 2'd0,
    CS_ALNUM = 2'd1,
    CS_ALPHA = 2'd2,
    CS_DIGIT = 2'd3
  } charset_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SELECT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSWORD_LENGTH = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GROUP_W    = 7;
  localparam int unsigned BUF_W      = 7;
  localparam int unsigned HELD_W     = 3;

  localparam logic [LEN_W-1:0] LENGTH_RESET = 16'd10;

  typedef struct packed {
    logic [CHAR_W-1:0] symbol_char;
    logic              last_of_password;
  } result_t;

  // Group width per character set
  function automatic logic [2:0] group_bits(input charset_t cs);
    case (cs)
      CS_PRINT: group_bits = 3'd7;
      CS_ALNUM: group_bits = 3'd6;
      CS_ALPHA: group_bits = 3'd6;
      CS_DIGIT: group_bits = 3'd4;
      default:  group_bits = 3'd4;
    endcase
  endfunction

  // Number of symbols per character set
  function automatic logic [GROUP_W-1:0] set_size(input charset_t cs);
    case (cs)
      CS_PRINT: set_size = 7'd95;
      CS_ALNUM: set_size = 7'd62;
      CS_ALPHA: set_size = 7'd52;
      CS_DIGIT: set_size = 7'd10;
      default:  set_size = 7'd10;
    endcase
  endfunction

  // Symbol table: group value to ASCII code (group is below set_size)
  function automatic logic [CHAR_W-1:0] symbol_of(input charset_t cs,
                                                 input logic [GROUP_W-1:0] g);
    logic [CHAR_W-1:0] c;
    c = 7'h20;
    case (cs)
      CS_PRINT: c = 7'h20 + g;
      CS_ALNUM, CS_ALPHA: begin
        if (g < 7'd26)      c = 7'h61 + g;
        else if (g < 7'd52) c = 7'h41 + (g - 7'd26);
        else if (g < 7'd61) c = 7'h31 + (g - 7'd52);
        else                c = 7'h30;
      end
      CS_DIGIT: begin
        if (g < 7'd9) c = 7'h31 + g;
        else          c = 7'h30;
      end
      default: c = 7'h20;
    endcase
    symbol_of = c;
  endfunction

endpackage

@@ rtl/random_bits_to_charset_symbols_unit.sv @@
// Random byte to password symbol mapper. Each accepted item is one random
// byte, appended most significant bit first to a small bit buffer; in the
// same cycle up to two groups of k bits (k = 7 printable, 6 alphanumeric or
// alpha, 4 digits) are taken from it. A group at or above the set size is
// dropped, any other becomes one output item holding the ASCII code and a
// flag that marks the last character of each password of password_length
// characters (a length of zero acts as one). Leftover bits carry over to
// the next byte. Input items are taken one per cycle whenever the result
// queue has room for two more results, so the input rate is one byte per
// cycle as long as the consumer takes results about as fast as they come;
// the output side delivers at most one result per cycle from a queue of
// QUEUE_DEPTH entries, and that drain rate sets the sustained figure when
// a charset yields more than one result per byte. Configuration writes
// take effect at once and do not clear the buffer or the character count.
module random_bits_to_charset_symbols_unit
  import rbcs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_random_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_symbol_char,
  output logic                  out_last_of_password,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

  // Configuration registers
  charset_t         charset_r;
  logic [LEN_W-1:0] length_r;

  // Bit buffer and password counter
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;

  // Result queue, head at entry 0
  result_t          q_r [QUEUE_DEPTH];
  result_t          q_nxt [QUEUE_DEPTH];
  result_t          q_sh [QUEUE_DEPTH];
  logic [CNT_W-1:0] fill_r, fill_nxt;

  logic push, pop;

  // Extraction datapath
  logic [BUF_W+BYTE_W-1:0] full;
  logic [3:0]              avail, sh1, sh2, rem;
  logic [2:0]              k;
  logic [GROUP_W-1:0]      gmask, grp1, grp2, size;
  logic                    take2, v0, v1;
  logic [LEN_W-1:0]        len_eff, count_mid;
  logic [LEN_W:0]          inc0, inc1;
  logic                    last0, last1;
  result_t                 res0, res1, first;
  logic [1:0]              n_res;
  logic [CNT_W-1:0]        base;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  // Hold off input unless two results fit
  assign in_stall = fill_r > ROOM_LIMIT;

  assign out_valid            = fill_r != '0;
  assign out_symbol_char      = q_r[0].symbol_char;
  assign out_last_of_password = q_r[0].last_of_password;

  always_comb begin
    k     = group_bits(charset_r);
    size  = set_size(charset_r);
    gmask = 7'h7f >> (3'd7 - k);
    full  = {buf_r, in_random_byte};
    avail = {1'b0, held_r} + 4'd8;

    // First group always fits: at least eight bits are held
    sh1   = avail - {1'b0, k};
    grp1  = GROUP_W'(full >> sh1) & gmask;
    take2 = sh1 >= {1'b0, k};
    sh2   = sh1 - {1'b0, k};
    grp2  = GROUP_W'(full >> sh2) & gmask;
    rem   = take2 ? sh2 : sh1;

    buf_nxt  = BUF_W'(full & ((15'd1 << rem) - 15'd1));
    held_nxt = rem[HELD_W-1:0];

    v0 = grp1 < size;
    v1 = take2 && (grp2 < size);

    // Password counter, first result then second
    len_eff   = (length_r == '0) ? LEN_W'(1) : length_r;
    inc0      = {1'b0, count_r} + 1'b1;
    last0     = inc0 >= {1'b0, len_eff};
    count_mid = v0 ? (last0 ? '0 : inc0[LEN_W-1:0]) : count_r;
    inc1      = {1'b0, count_mid} + 1'b1;
    last1     = inc1 >= {1'b0, len_eff};
    count_nxt = v1 ? (last1 ? '0 : inc1[LEN_W-1:0]) : count_mid;

    res0.symbol_char      = symbol_of(charset_r, grp1);
    res0.last_of_password = last0;
    res1.symbol_char      = symbol_of(charset_r, grp2);
    res1.last_of_password = last1;

    // Pack accepted results to the front
    first = v0 ? res0 : res1;
    n_res = push ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
  end

  // Queue next state: advance on pop, append new results behind the rest
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      q_sh[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_sh[QUEUE_DEPTH-1] = q_r[QUEUE_DEPTH-1];

    base = fill_r - CNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (CNT_W'(i) == base && n_res != 2'd0) begin
        q_nxt[i] = first;
      end else if (CNT_W'(i) == base + 1'b1 && n_res == 2'd2) begin
        q_nxt[i] = res1;
      end else begin
        q_nxt[i] = q_sh[i];
      end
    end
    fill_nxt = base + CNT_W'(n_res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_r <= CS_PRINT;
      length_r  <= LENGTH_RESET;
      buf_r     <= '0;
      held_r    <= '0;
      count_r   <= '0;
      fill_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CHARSET_SELECT:  charset_r <= charset_t'(cfg_wr_data[1:0]);
          CFG_PASSWORD_LENGTH: length_r  <= cfg_wr_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        buf_r   <= buf_nxt;
        held_r  <= held_nxt;
        count_r <= count_nxt;
      end
      fill_r <= fill_nxt;
    end
  end

  // Queue payload carries no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // Queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // Fewer bits than the widest group stay behind after each byte
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 3'd6)
    else $error("bit buffer holds too many bits");

  // Bits above the held count are always clear
  a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_r >> held_r) == '0)
    else $error("stale bits in bit buffer");

  // A byte that yields nothing and no pop leaves the queue as it was
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!pop && (!push || (!v0 && !v1))) |=> fill_r == $past(fill_r))
    else $error("queue fill changed without push or pop");

endmodule

@@ dv/random_bits_to_charset_symbols_unit_tb.sv @@
module random_bits_to_charset_symbols_unit_tb;
  import rbcs_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 16;       // covers bytes still in flight that yield nothing
  localparam int RANDOM_ITEMS  = 650;
  localparam int LIMIT_CYCLES  = 600000;

  // Character tables, first character in the most significant byte
  localparam logic [8*62-1:0] ALNUM_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
  localparam logic [8*10-1:0] DIGIT_CHARS = "1234567890";

  localparam result_t NO_RES = '0;

  // One row of the directed plan: either a register write or a byte.
  // exp_n < 0 means the symbol predictor supplies the expectation.
  typedef struct {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [BYTE_W-1:0]     rnd;
    int                    exp_n;
    result_t               exp0;
    result_t               exp1;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_random_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_symbol_char;
  logic                  out_last_of_password;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  // Typed expectation riding along with the byte on the input channel
  int      tag_n = -1;
  result_t tag_r0 = '0;
  result_t tag_r1 = '0;

  // Symbol predictor state and its copy of the registers
  charset_t cur_charset = CS_PRINT;
  int       cur_length  = 10;
  int       bits_q      = 0;
  int       bits_n      = 0;
  int       pw_count    = 0;

  result_t symbols_due[$];
  int      mismatches = 0;
  int      items_sent = 0;

  // Traffic shaping knobs, changed per phase by the stimulus
  int gap_mode = 1;
  int stall_pct = 20;
  int stall_left = 0;

  plan_row_t plan[$];

  random_bits_to_charset_symbols_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_random_byte       (in_random_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_symbol_char      (out_symbol_char),
    .out_last_of_password (out_last_of_password),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wr_data          (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ASCII code of group value g in charset cs (g already below the set size)
  function automatic logic [CHAR_W-1:0] char_for(input charset_t cs, input int g);
    logic [CHAR_W-1:0] c;
    case (cs)
      CS_PRINT: c = CHAR_W'(32 + g);
      CS_DIGIT: c = DIGIT_CHARS[8*(9-g) +: CHAR_W];
      default:  c = ALNUM_CHARS[8*(61-g) +: CHAR_W];   // alpha is the first 52
    endcase
    return c;
  endfunction

  // Advance the predictor by one byte; return how many symbols it yields
  function automatic int map_byte(input logic [BYTE_W-1:0] v,
                                  output result_t r0, output result_t r1);
    int      k;
    int      size;
    int      grp;
    int      lim;
    int      n;
    int      t;
    logic    is_last;
    result_t r;
    r0 = '0;
    r1 = '0;
    n  = 0;
    case (cur_charset)
      CS_PRINT: begin k = 7; size = 95; end
      CS_ALNUM: begin k = 6; size = 62; end
      CS_ALPHA: begin k = 6; size = 52; end
      default:  begin k = 4; size = 10; end
    endcase
    // append MSB first, keep 15 bits
    bits_q = ((bits_q << 8) | int'(v)) & 'h7fff;
    bits_n += 8;
    lim = (cur_length == 0) ? 1 : cur_length;
    // at most two groups per byte, rejected groups count too
    for (t = 0; t < 2 && bits_n >= k; t++) begin
      grp = (bits_q >> (bits_n - k)) & ((1 << k) - 1);
      bits_n -= k;
      bits_q &= (1 << bits_n) - 1;
      if (grp < size) begin
        is_last = (pw_count + 1 >= lim);
        r.symbol_char      = char_for(cur_charset, grp);
        r.last_of_password = is_last;
        if (n == 0) r0 = r;
        else        r1 = r;
        n++;
        pw_count = is_last ? 0 : pw_count + 1;
      end
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict on accepted bytes and check accepted symbols in one process, so
  // a symbol that comes out in the cycle after its byte still finds its entry.
  result_t mon_r0, mon_r1, want;
  int      mon_n;
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_CHARSET_SELECT) cur_charset = charset_t'(cfg_wr_data[1:0]);
        else if (cfg_index == CFG_PASSWORD_LENGTH) cur_length = int'(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        mon_n = map_byte(in_random_byte, mon_r0, mon_r1);
        // typed rows override the predictor, which still advances
        if (tag_n >= 0) begin
          if (tag_n > 0) symbols_due.push_back(tag_r0);
          if (tag_n > 1) symbols_due.push_back(tag_r1);
        end else begin
          if (mon_n > 0) symbols_due.push_back(mon_r0);
          if (mon_n > 1) symbols_due.push_back(mon_r1);
        end
      end
      if (out_valid && !out_stall) begin
        if (symbols_due.size() == 0) begin
          report_mismatch($sformatf("unexpected symbol %h last %b",
                                    out_symbol_char, out_last_of_password));
        end else begin
          want = symbols_due.pop_front();
          if (out_symbol_char !== want.symbol_char)
            report_mismatch($sformatf("symbol_char got %h want %h",
                                      out_symbol_char, want.symbol_char));
          if (out_last_of_password !== want.last_of_password)
            report_mismatch($sformatf("last_of_password got %b want %b (symbol %h)",
                                      out_last_of_password, want.last_of_password,
                                      want.symbol_char));
        end
      end
    end
  end

  // Receiver back-pressure: bursts of stall, mostly short, some long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) - 1
                                                : $urandom_range(1, 3) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Wait until every predicted symbol has come out, then let the block settle
  task automatic wait_drained();
    do @(posedge clk); while (symbols_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drive one byte and hold it until accepted; valid stays high afterward
  task automatic send_item(input logic [BYTE_W-1:0] v, input int n,
                           input result_t r0, input result_t r1);
    in_valid       <= 1'b1;
    in_random_byte <= v;
    tag_n          <= n;
    tag_r0         <= r0;
    tag_r1         <= r1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Optional idle cycles after an item; scramble the payload while idle
  task automatic idle_gap();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (gap_mode != 0) begin
      if (r >= 92)      gap = $urandom_range(8, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid       <= 1'b0;
      in_random_byte <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic plan_row_t step_row(input logic [BYTE_W-1:0] v, input int n,
                                         input result_t r0, input result_t r1);
    plan_row_t p;
    p.is_reg = 1'b0; p.idx = '0; p.val = '0;
    p.rnd = v; p.exp_n = n; p.exp0 = r0; p.exp1 = r1;
    return p;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t p;
    p.is_reg = 1'b1; p.idx = idx; p.val = val;
    p.rnd = '0; p.exp_n = -1; p.exp0 = NO_RES; p.exp1 = NO_RES;
    return p;
  endfunction

  initial begin
    int phase;
    int n_items;
    int pick;
    logic [BYTE_W-1:0] v;

    // After reset: printable set, length 10, empty buffer
    plan.push_back(step_row(8'h00, 1, {7'h20, 1'b0}, NO_RES));
    plan.push_back(step_row(8'h00, 1, {7'h20, 1'b0}, NO_RES));
    plan.push_back(step_row(8'hFF, 1, {7'h3F, 1'b0}, NO_RES));
    plan.push_back(step_row(8'hFF, 0, NO_RES, NO_RES));        // group 127 is rejected
    plan.push_back(step_row(8'hAA, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h55, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h7F, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h80, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h01, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'hFE, -1, NO_RES, NO_RES));
    // every character closes a password
    plan.push_back(reg_row(CFG_PASSWORD_LENGTH, 16'd1));
    plan.push_back(step_row(8'h5E, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'hC3, -1, NO_RES, NO_RES));
    // digits with junk in the unused register bits; held bits carry over
    plan.push_back(reg_row(CFG_CHARSET_SELECT, {14'h3FFC, CS_DIGIT}));
    plan.push_back(step_row(8'h00, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h99, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'hFF, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h12, -1, NO_RES, NO_RES));
    // length zero acts as one
    plan.push_back(reg_row(CFG_CHARSET_SELECT, {14'h0, CS_ALNUM}));
    plan.push_back(reg_row(CFG_PASSWORD_LENGTH, 16'd0));
    plan.push_back(step_row(8'hF8, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h3D, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'hFF, -1, NO_RES, NO_RES));
    plan.push_back(reg_row(CFG_CHARSET_SELECT, {14'h1555, CS_ALPHA}));
    plan.push_back(reg_row(CFG_PASSWORD_LENGTH, 16'hFFFF));
    plan.push_back(step_row(8'h34, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'hCF, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h68, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h1B, -1, NO_RES, NO_RES));
    // lower the length below the running count: next character is last
    plan.push_back(reg_row(CFG_PASSWORD_LENGTH, 16'd2));
    plan.push_back(step_row(8'h00, -1, NO_RES, NO_RES));
    plan.push_back(step_row(8'h7C, -1, NO_RES, NO_RES));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].rnd, plan[i].exp_n, plan[i].exp0, plan[i].exp1);
        idle_gap();
      end
    end

    // Random part: phases of fresh settings and traffic shape
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_CHARSET_SELECT, {14'($urandom), 2'($urandom_range(0, 3))});
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0:       write_reg(CFG_PASSWORD_LENGTH, 16'd0);
          1:       write_reg(CFG_PASSWORD_LENGTH, 16'd1);
          2:       write_reg(CFG_PASSWORD_LENGTH, 16'hFFFF);
          3:       write_reg(CFG_PASSWORD_LENGTH, 16'($urandom));
          default: write_reg(CFG_PASSWORD_LENGTH, 16'($urandom_range(2, 12)));
        endcase
      end
      gap_mode = $urandom_range(0, 3);                   // zero gives back-to-back items
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        2:       stall_pct = 30;
        default: stall_pct = 60;
      endcase
      n_items = $urandom_range(8, 60);
      for (int i = 0; i < n_items; i++) begin
        // hold off the sender until everything predicted has come out
        if (i == n_items / 2 && (phase == 0 || $urandom_range(0, 4) == 0)) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        pick = $urandom_range(0, 7);
        if (pick == 0)      v = 8'h00;
        else if (pick == 1) v = 8'hFF;
        else                v = BYTE_W'($urandom);
        send_item(v, -1, NO_RES, NO_RES);
        idle_gap();
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("[random_bits_to_charset_symbols_unit] OK");
    end else begin
      $display("[random_bits_to_charset_symbols_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[random_bits_to_charset_symbols_unit] ERROR");
    $finish;
  end

endmodule
